FILE: sv/keyframe_request_pacer_core_assert.svh
// Assertion helpers for the pacer modules, used by the back stage (kpr_back).
`ifndef KEYFRAME_REQUEST_PACER_CORE_ASSERT_SVH
`define KEYFRAME_REQUEST_PACER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pacer assertion failed");

// Next-cycle implication, disabled during reset.
`define KPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pacer assertion failed");

`endif

FILE: sv/kpr_pkg.sv
package kpr_pkg;

    localparam int TICK_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_ENABLED    = 3'd0;
    localparam logic [2:0] CFG_PLI_PERIOD = 3'd1;
    localparam logic [2:0] CFG_KF_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_SRC_SSRC   = 3'd3;
    localparam logic [2:0] CFG_SINK_SSRC  = 3'd4;

    // Reset values of the registers
    localparam logic        RST_ENABLED    = 1'b1;
    localparam logic [15:0] RST_PLI_PERIOD = 16'd200;
    localparam logic [15:0] RST_KF_TIMEOUT = 16'd4000;

    // Input action codes
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_INBOUND = 2'd1;
    localparam logic [1:0] ACT_OUTBND  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_FWD_IN  = 2'd0;
    localparam logic [1:0] KIND_FWD_OUT = 2'd1;
    localparam logic [1:0] KIND_PLI     = 2'd2;
    localparam logic [1:0] KIND_FIR     = 2'd3;

    typedef enum logic [1:0] {
        OP_FWD_IN,
        OP_FWD_OUT,
        OP_PLI,
        OP_FIR
    } t_op;

    // One queued command: FIR carries the first of its three sequence numbers
    typedef struct packed {
        t_op        op;
        logic [7:0] seq;
    } t_cmd;

    typedef struct packed {
        logic        enabled;
        logic [15:0] pli_period;
        logic [15:0] kf_timeout;
        logic [31:0] source_ssrc;
        logic [31:0] sink_ssrc;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

FILE: sv/kpr_front.sv
module kpr_front #(
    parameter int TICK_WIDTH = kpr_pkg::TICK_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kpr_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic [1:0]    i_action,
    input  logic          i_is_keyframe,
    input  logic          i_is_pli,
    output logic          o_push,
    output kpr_pkg::t_cmd o_cmd
);

    localparam int CW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    typedef enum logic [1:0] {
        TMR_NONE,
        TMR_HALF,
        TMR_PLI
    } t_tmr;

    logic                  r_waiting, n_waiting;
    logic [TICK_WIDTH-1:0] r_since,   n_since;
    t_tmr                  r_pend,    n_pend;
    logic [15:0]           r_cd,      n_cd;
    logic [7:0]            r_fir,     n_fir;

    logic                  cmd_valid;
    kpr_pkg::t_cmd         cmd;
    logic [15:0]           period1;
    logic [15:0]           half1;
    logic [15:0]           cd_dec;
    logic                  timed_out;

    assign period1 = (i_cfg.pli_period == 16'd0) ? 16'd1 : i_cfg.pli_period;
    assign half1   = (i_cfg.kf_timeout[15:1] == 15'd0) ? 16'd1
                                                       : {1'b0, i_cfg.kf_timeout[15:1]};
    assign cd_dec  = (r_cd != 16'd0) ? r_cd - 16'd1 : 16'd0;

    always_comb begin
        n_waiting = r_waiting;
        n_since   = r_since;
        n_pend    = r_pend;
        n_cd      = r_cd;
        n_fir     = r_fir;
        cmd_valid = 1'b0;
        cmd.op    = kpr_pkg::OP_FWD_IN;
        cmd.seq   = 8'd0;
        timed_out = 1'b0;
        unique case (i_action)
            kpr_pkg::ACT_TICK: begin
                if (r_since != {TICK_WIDTH{1'b1}}) begin
                    n_since = r_since + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
                end
                timed_out = CW'(n_since) >= CW'(i_cfg.kf_timeout);
                if (r_pend != TMR_NONE) begin
                    n_cd = cd_dec;
                    if (cd_dec == 16'd0) begin
                        if (r_pend == TMR_HALF) begin
                            n_waiting = 1'b1;
                            if (i_cfg.enabled) begin
                                n_pend = TMR_PLI;
                                n_cd   = period1;
                            end else begin
                                n_pend = TMR_NONE;
                                n_cd   = 16'd0;
                            end
                        end else if (timed_out) begin
                            cmd_valid = 1'b1;
                            cmd.op    = kpr_pkg::OP_FIR;
                            cmd.seq   = r_fir;
                            n_fir     = r_fir + 8'd3;
                            n_waiting = 1'b0;
                            n_pend    = TMR_NONE;
                            n_cd      = 16'd0;
                        end else begin
                            cmd_valid = 1'b1;
                            cmd.op    = kpr_pkg::OP_PLI;
                            if (r_waiting && i_cfg.enabled) begin
                                n_pend = TMR_PLI;
                                n_cd   = period1;
                            end else begin
                                n_pend = TMR_NONE;
                                n_cd   = 16'd0;
                            end
                        end
                    end
                end
            end
            kpr_pkg::ACT_INBOUND: begin
                if (i_cfg.enabled && i_is_keyframe) begin
                    n_since   = '0;
                    n_waiting = 1'b0;
                    n_pend    = TMR_HALF;
                    n_cd      = half1;
                end
                cmd_valid = 1'b1;
                cmd.op    = kpr_pkg::OP_FWD_IN;
            end
            kpr_pkg::ACT_OUTBND: begin
                // drop a PLI while a request is already waiting
                if (i_cfg.enabled && i_is_pli && r_waiting) begin
                    cmd_valid = 1'b0;
                end else begin
                    if (i_cfg.enabled && i_is_pli) begin
                        n_waiting = 1'b1;
                        n_pend    = TMR_PLI;
                        n_cd      = period1;
                    end
                    cmd_valid = 1'b1;
                    cmd.op    = kpr_pkg::OP_FWD_OUT;
                end
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_since   <= '0;
            r_pend    <= TMR_NONE;
            r_cd      <= 16'd0;
            r_fir     <= 8'd0;
        end else if (i_accept) begin
            r_waiting <= n_waiting;
            r_since   <= n_since;
            r_pend    <= n_pend;
            r_cd      <= n_cd;
            r_fir     <= n_fir;
        end
    end

    assign o_push = i_accept && cmd_valid;
    assign o_cmd  = cmd;

endmodule

FILE: sv/kpr_queue.sv
module kpr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kpr_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output kpr_pkg::t_cmd   o_data,
    output kpr_pkg::t_qstat o_stat
);

    localparam int AW = $clog2(kpr_pkg::QUEUE_DEPTH);

    kpr_pkg::t_cmd r_mem [kpr_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (AW+1)'(kpr_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

FILE: sv/kpr_back.sv
`include "keyframe_request_pacer_core_assert.svh"

module kpr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kpr_pkg::t_cfg   i_cfg,
    input  kpr_pkg::t_cmd   i_cmd,
    input  kpr_pkg::t_qstat i_qstat,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_fir_seq,
    output logic [31:0]     o_media_ssrc,
    output logic [31:0]     o_sender_ssrc,
    output logic            o_last
);

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_seq;
    logic       r_last;
    logic [1:0] r_left;
    logic [7:0] r_bseq;
    logic       load;

    // the output slot is free or empties at this edge
    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && (r_left == 2'd0) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 2'd0;
        end else if (load) begin
            if (r_left != 2'd0) begin
                r_valid <= 1'b1;
                r_kind  <= kpr_pkg::KIND_FIR;
                r_seq   <= r_bseq;
                r_last  <= (r_left == 2'd1);
                r_left  <= r_left - 2'd1;
                r_bseq  <= r_bseq + 8'd1;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_seq   <= 8'd0;
                r_last  <= 1'b1;
                unique case (i_cmd.op)
                    kpr_pkg::OP_FWD_IN:  r_kind <= kpr_pkg::KIND_FWD_IN;
                    kpr_pkg::OP_FWD_OUT: r_kind <= kpr_pkg::KIND_FWD_OUT;
                    kpr_pkg::OP_PLI:     r_kind <= kpr_pkg::KIND_PLI;
                    kpr_pkg::OP_FIR: begin
                        r_kind <= kpr_pkg::KIND_FIR;
                        r_seq  <= i_cmd.seq;
                        r_last <= 1'b0;
                        r_left <= 2'd2;
                        r_bseq <= i_cmd.seq + 8'd1;
                    end
                    default: r_kind <= kpr_pkg::KIND_FWD_IN;
                endcase
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_fir_seq     = r_seq;
    assign o_last        = r_last;
    // generated requests carry the stream identifiers, forwarded packets zero
    assign o_media_ssrc  = r_kind[1] ? i_cfg.source_ssrc : 32'd0;
    assign o_sender_ssrc = r_kind[1] ? i_cfg.sink_ssrc : 32'd0;

    `KPR_ASSERT_NOW(a_burst_shown, i_clk, i_rst_n, r_left != 2'd0,
                    r_valid && r_kind == kpr_pkg::KIND_FIR && !r_last)
    `KPR_ASSERT_NOW(a_notlast_fir, i_clk, i_rst_n, r_valid && !r_last,
                    r_kind == kpr_pkg::KIND_FIR)
    `KPR_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_qstat.empty)
    `KPR_ASSERT_NEXT(a_burst_step, i_clk, i_rst_n,
                     r_left == 2'd2 && !i_out_stall,
                     r_left == 2'd1 && r_seq == $past(r_seq) + 8'd1)

endmodule

FILE: sv/keyframe_request_pacer_core.sv
// Keyframe request pacer.
// Input channel (i_in_valid / o_in_stall) takes one beat per item: a tick,
// an inbound media packet (with keyframe flag) or an outbound feedback packet
// (with PLI flag). Output channel (o_out_valid / i_out_stall) gives result
// beats: forwarded packet marks, generated PLIs, or bursts of three FIRs; o_last
// flags the final beat caused by one input item.
// Throughput: one input beat per cycle while the command queue has room; the
// front stage updates all pacing state in the cycle it accepts a beat. Output
// runs at one beat per cycle while the receiver does not stall, so an FIR
// burst holds the back end for its three beats; the four-entry queue absorbs
// that and the front stalls only when full. An accepted input beat is written
// into the queue and then loaded into the output register.
// Configuration is a plain write port (i_cfg_we / i_cfg_index / i_cfg_wdata);
// write only while idle. Reset restores the register defaults and clears the
// pacing state, the queue and the output register; no clearing pass is needed.
// When the receiver stalls, the output beat holds; the queue fills behind it
// and then o_in_stall rises until the output drains.
module keyframe_request_pacer_core #(
    parameter int TICK_WIDTH = kpr_pkg::TICK_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic        i_is_keyframe,
    input  logic        i_is_pli,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_fir_seq,
    output logic [31:0] o_media_ssrc,
    output logic [31:0] o_sender_ssrc,
    output logic        o_last
);

    kpr_pkg::t_cfg   r_cfg;
    kpr_pkg::t_cmd   push_cmd;
    kpr_pkg::t_cmd   pop_cmd;
    kpr_pkg::t_qstat qstat;
    logic            accept;
    logic            push;
    logic            pop;

    // Register bank: hold until written, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled     <= kpr_pkg::RST_ENABLED;
            r_cfg.pli_period  <= kpr_pkg::RST_PLI_PERIOD;
            r_cfg.kf_timeout  <= kpr_pkg::RST_KF_TIMEOUT;
            r_cfg.source_ssrc <= 32'd0;
            r_cfg.sink_ssrc   <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kpr_pkg::CFG_ENABLED:    r_cfg.enabled     <= i_cfg_wdata[0];
                kpr_pkg::CFG_PLI_PERIOD: r_cfg.pli_period  <= i_cfg_wdata[15:0];
                kpr_pkg::CFG_KF_TIMEOUT: r_cfg.kf_timeout  <= i_cfg_wdata[15:0];
                kpr_pkg::CFG_SRC_SSRC:   r_cfg.source_ssrc <= i_cfg_wdata;
                kpr_pkg::CFG_SINK_SSRC:  r_cfg.sink_ssrc   <= i_cfg_wdata;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Stall the input only on a full queue
    assign o_in_stall = qstat.full;
    assign accept     = i_in_valid && !qstat.full;

    kpr_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_is_keyframe (i_is_keyframe),
        .i_is_pli      (i_is_pli),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    kpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_stat  (qstat)
    );

    kpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (pop_cmd),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_fir_seq     (o_fir_seq),
        .o_media_ssrc  (o_media_ssrc),
        .o_sender_ssrc (o_sender_ssrc),
        .o_last        (o_last)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Clock period, settle time after the last expected beat and the run limit
    localparam int  HALF_PERIOD_NS = 6;
    localparam int  RESET_CYCLES   = 10;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  QUIET_GUARD    = 5000;
    localparam int  AGE_W          = kpr_pkg::TICK_WIDTH_DEF;
    localparam real RUN_LIMIT_NS   = 24_000_000.0;

    // Action code the pacer ignores
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    // Timer held by the pacer: at most one of these is pending at a time
    typedef enum logic [1:0] {
        TMR_IDLE,
        TMR_HALF,
        TMR_CHECK
    } t_timer;

    // One result beat as the output channel should present it
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  seq;
        logic [31:0] media;
        logic [31:0] sender;
        logic        last;
    } t_req_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic        i_is_keyframe;
    logic        i_is_pli;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_fir_seq;
    logic [31:0] o_media_ssrc;
    logic [31:0] o_sender_ssrc;
    logic        o_last;

    // Pacer state and register copies kept by the testbench
    logic             m_enabled;
    logic [15:0]      m_pli_period;
    logic [15:0]      m_kf_timeout;
    logic [31:0]      m_src_ssrc;
    logic [31:0]      m_sink_ssrc;
    logic             m_waiting;
    logic [AGE_W-1:0] m_age;
    t_timer           m_timer;
    logic [15:0]      m_countdown;
    logic [7:0]       m_fir_seq;

    // Result beats predicted but not yet seen, oldest first
    t_req_beat pending_reqs[$];
    t_req_beat want;

    int errors      = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int plis_seen   = 0;
    int firs_seen   = 0;
    int plis_drop   = 0;
    int reg_writes  = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_run   = 0;

    keyframe_request_pacer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_is_keyframe (i_is_keyframe),
        .i_is_pli      (i_is_pli),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_fir_seq     (o_fir_seq),
        .o_media_ssrc  (o_media_ssrc),
        .o_sender_ssrc (o_sender_ssrc),
        .o_last        (o_last)
    );

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Build a result beat: generated requests carry the stream identifiers,
    // forwarded packet marks carry zeros
    function automatic t_req_beat make_req(input logic [1:0] kind, input logic [7:0] seq);
        t_req_beat r;
        logic      gen;
        gen      = (kind == kpr_pkg::KIND_PLI) || (kind == kpr_pkg::KIND_FIR);
        r.kind   = kind;
        r.seq    = seq;
        r.media  = gen ? m_src_ssrc : 32'd0;
        r.sender = gen ? m_sink_ssrc : 32'd0;
        r.last   = 1'b0;
        return r;
    endfunction

    // Arm the PLI-period check while a request waits and pacing is on;
    // otherwise drop whatever timer was pending. A zero period counts as one.
    task automatic arm_pli_check();
        if (m_waiting && m_enabled) begin
            m_timer     = TMR_CHECK;
            m_countdown = (m_pli_period == 16'd0) ? 16'd1 : m_pli_period;
        end else begin
            m_timer     = TMR_IDLE;
            m_countdown = 16'd0;
        end
    endtask

    // Advance the pacer state by one accepted beat and queue its results
    task automatic predict_pacer(input logic [1:0] act, input logic key, input logic pli);
        t_req_beat   beats[3];
        int          n;
        t_timer      fired;
        logic [15:0] half;
        n = 0;
        case (act)
            kpr_pkg::ACT_TICK: begin
                // Age saturates rather than wrapping
                if (m_age != '1) m_age = m_age + 1'b1;
                if (m_timer != TMR_IDLE) begin
                    if (m_countdown != 16'd0) m_countdown = m_countdown - 1'b1;
                    if (m_countdown == 16'd0) begin
                        fired   = m_timer;
                        m_timer = TMR_IDLE;
                        if (fired == TMR_HALF) begin
                            m_waiting = 1'b1;
                            arm_pli_check();
                        end else if (m_age >= m_kf_timeout) begin
                            // Timed out: three FIRs with consecutive numbers
                            for (int i = 0; i < 3; i++) begin
                                beats[n] = make_req(kpr_pkg::KIND_FIR, m_fir_seq);
                                n++;
                                m_fir_seq = m_fir_seq + 1'b1;
                            end
                            m_waiting   = 1'b0;
                            m_countdown = 16'd0;
                        end else begin
                            beats[n] = make_req(kpr_pkg::KIND_PLI, 8'd0);
                            n++;
                            arm_pli_check();
                        end
                    end
                end
            end
            kpr_pkg::ACT_INBOUND: begin
                if (m_enabled && key) begin
                    half        = m_kf_timeout >> 1;
                    m_age       = '0;
                    m_waiting   = 1'b0;
                    m_timer     = TMR_HALF;
                    m_countdown = (half == 16'd0) ? 16'd1 : half;
                end
                beats[n] = make_req(kpr_pkg::KIND_FWD_IN, 8'd0);
                n++;
            end
            kpr_pkg::ACT_OUTBND: begin
                if (m_enabled && pli && m_waiting) begin
                    // A request is already waiting: drop the PLI outright
                    plis_drop++;
                end else begin
                    if (m_enabled && pli) begin
                        m_waiting = 1'b1;
                        arm_pli_check();
                    end
                    beats[n] = make_req(kpr_pkg::KIND_FWD_OUT, 8'd0);
                    n++;
                end
            end
            default: begin
                // Unknown action: ignored
            end
        endcase
        for (int i = 0; i < n; i++) begin
            beats[i].last = (i == n - 1);
            pending_reqs.push_back(beats[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register at a falling edge, then drop the write enable before
    // returning so that back-to-back writes never touch the enable twice in one step
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            kpr_pkg::CFG_ENABLED:    m_enabled    = data[0];
            kpr_pkg::CFG_PLI_PERIOD: m_pli_period = data[15:0];
            kpr_pkg::CFG_KF_TIMEOUT: m_kf_timeout = data[15:0];
            kpr_pkg::CFG_SRC_SSRC:   m_src_ssrc   = data;
            kpr_pkg::CFG_SINK_SSRC:  m_sink_ssrc  = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic en, input logic [15:0] period,
                             input logic [15:0] timeout, input logic [31:0] src,
                             input logic [31:0] sink);
        write_reg(kpr_pkg::CFG_ENABLED, {31'd0, en});
        write_reg(kpr_pkg::CFG_PLI_PERIOD, {16'd0, period});
        write_reg(kpr_pkg::CFG_KF_TIMEOUT, {16'd0, timeout});
        write_reg(kpr_pkg::CFG_SRC_SSRC, src);
        write_reg(kpr_pkg::CFG_SINK_SSRC, sink);
    endtask

    // Offer one input beat; called at a falling edge, returns at a falling
    // edge. Valid stays high across a burst and drops only for a gap.
    task automatic drive_beat(input logic [1:0] act, input logic key, input logic pli);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_is_keyframe <= key;
        i_is_pli      <= pli;
        do @(posedge i_clk); while (o_in_stall);
        predict_pacer(act, key, pli);
        if (act != ACT_UNKNOWN) beats_in++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) drive_beat(kpr_pkg::ACT_TICK, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
    endtask

    // Hold the sender off until every predicted beat has come, then let the
    // block settle so that register writes land while it is idle
    task automatic await_quiet();
        int guard;
        i_in_valid <= 1'b0;
        burst_left = 0;
        guard      = 0;
        while (pending_reqs.size() != 0 && guard < QUIET_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        if (pending_reqs.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_reqs.size());
            errors++;
            pending_reqs.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: plain forwarding, unknown action, keyframe
    // arming the half timeout, a PLI replacing it, and a repeat PLI dropped
    task automatic test_reset_defaults();
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b0, 1'b1);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b1, 1'b0);
        drive_beat(ACT_UNKNOWN, 1'b1, 1'b1);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        drive_beat(kpr_pkg::ACT_TICK, 1'b0, 1'b0);
        await_quiet();
    endtask

    // Shortest period and timeout, then a PLI path with a longer timeout;
    // the identifiers take all-ones and all-zeros
    task automatic test_register_extremes();
        write_all(1'b1, 16'd1, 16'd2, 32'hFFFF_FFFF, 32'h0000_0000);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        send_ticks(2);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        send_ticks(1);
        await_quiet();
        write_all(1'b1, 16'd1, 16'd10, 32'h0000_0000, 32'hFFFF_FFFF);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b1);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b1, 1'b1);
        send_ticks(2);
        await_quiet();
    endtask

    // Pacing off: packets pass unchanged, a pending check still fires once
    // without rearming, and a half timeout expires silently
    task automatic test_pacing_disabled();
        write_all(1'b1, 16'd3, 16'd4, 32'h5A5A_0F0F, 32'hC3C3_A5A5);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        await_quiet();
        write_reg(kpr_pkg::CFG_ENABLED, 32'd0);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        send_ticks(5);
        await_quiet();
        write_reg(kpr_pkg::CFG_ENABLED, 32'd1);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        await_quiet();
        write_reg(kpr_pkg::CFG_ENABLED, 32'd0);
        send_ticks(2);
        await_quiet();
        write_reg(kpr_pkg::CFG_ENABLED, 32'd1);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        await_quiet();
    endtask

    // Zero period and a timeout whose half is zero both behave as one tick
    task automatic test_zero_period();
        write_all(1'b1, 16'd0, 16'd1, 32'h1234_5678, 32'h8765_4321);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        send_ticks(2);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        send_ticks(1);
        await_quiet();
    endtask

    // Back-to-back FIR bursts with the sequence number running on
    task automatic test_fir_bursts();
        write_all(1'b1, 16'd1, 16'd2, $urandom, $urandom);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        send_ticks(2);
        repeat (16) begin
            drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
            send_ticks(1);
        end
        await_quiet();
    endtask

    // Longest timeout: each check finds the timeout unmet, sends a PLI and
    // rearms; a keyframe then replaces the check with the half timeout
    task automatic test_long_timeout();
        write_all(1'b1, 16'd1, 16'hFFFF, 32'hDEAD_0001, 32'h0000_BEEF);
        drive_beat(kpr_pkg::ACT_OUTBND, 1'b0, 1'b1);
        send_ticks(3);
        drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'b0);
        send_ticks(2);
        await_quiet();
    endtask

    // Mostly well-formed sequences (keyframe or PLI followed by ticks) with
    // random content, mixed with loose packets, unknown actions and tick runs
    task automatic random_traffic_phase(input int count);
        int start;
        int r;
        start = beats_in;
        while (beats_in - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                drive_beat(kpr_pkg::ACT_INBOUND, 1'b1, 1'($urandom_range(0, 1)));
                send_ticks($urandom_range(1, 10));
            end else if (r < 34) begin
                drive_beat(kpr_pkg::ACT_OUTBND, 1'($urandom_range(0, 1)), 1'b1);
                send_ticks($urandom_range(1, 10));
            end else if (r < 56) begin
                send_ticks(1);
            end else if (r < 70) begin
                drive_beat(kpr_pkg::ACT_INBOUND, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (r < 86) begin
                drive_beat(kpr_pkg::ACT_OUTBND, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (r < 93) begin
                drive_beat(ACT_UNKNOWN, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else begin
                send_ticks($urandom_range(5, 30));
            end
        end
        await_quiet();
    endtask

    task automatic test_random_traffic();
        // Low extremes first, high extremes next, then random small settings
        write_all(1'b1, 16'd1, 16'd2, $urandom, $urandom);
        random_traffic_phase(14);
        write_all(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_traffic_phase(14);
        repeat (3) begin
            write_all($urandom_range(0, 4) != 0, 16'($urandom_range(1, 12)),
                      16'($urandom_range(2, 48)), $urandom, $urandom);
            random_traffic_phase(14);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls in stretches of random mode, including none at all
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(4, 40);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (o_kind == kpr_pkg::KIND_PLI) plis_seen++;
            if (o_kind == kpr_pkg::KIND_FIR) firs_seen++;
            if (pending_reqs.size() == 0) begin
                $error("unexpected result beat: kind %0d fir_seq %0d", o_kind, o_fir_seq);
                errors++;
            end else begin
                want = pending_reqs.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errors++;
                end
                if (o_fir_seq !== want.seq) begin
                    $error("fir_seq: expected %0d, got %0d", want.seq, o_fir_seq);
                    errors++;
                end
                if (o_media_ssrc !== want.media) begin
                    $error("media_ssrc: expected %h, got %h", want.media, o_media_ssrc);
                    errors++;
                end
                if (o_sender_ssrc !== want.sender) begin
                    $error("sender_ssrc: expected %h, got %h", want.sender, o_sender_ssrc);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= kpr_pkg::CFG_ENABLED;
        i_cfg_wdata   <= 32'd0;
        i_in_valid    <= 1'b0;
        i_action      <= kpr_pkg::ACT_TICK;
        i_is_keyframe <= 1'b0;
        i_is_pli      <= 1'b0;

        // Register defaults and cleared state, as after reset
        m_enabled    = kpr_pkg::RST_ENABLED;
        m_pli_period = kpr_pkg::RST_PLI_PERIOD;
        m_kf_timeout = kpr_pkg::RST_KF_TIMEOUT;
        m_src_ssrc   = 32'd0;
        m_sink_ssrc  = 32'd0;
        m_waiting    = 1'b0;
        m_age        = '0;
        m_timer      = TMR_IDLE;
        m_countdown  = 16'd0;
        m_fir_seq    = 8'd0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_pacing_disabled();
        test_zero_period();
        test_fir_bursts();
        test_long_timeout();
        test_random_traffic();
        await_quiet();

        $display("Run covered %0d input beats, %0d result beats (%0d PLI, %0d FIR),",
                 beats_in, beats_out, plis_seen, firs_seen);
        $display("%0d dropped PLIs and %0d register writes; %0d mismatches.",
                 plis_drop, reg_writes, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
